/* src/msgp_pkg.sv */
`default_nettype none

package msgp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [63:0] token_value;
    logic        ends_buffer;
  } out_word_t;

  localparam logic [3:0] KIND_NIL       = 4'd0;
  localparam logic [3:0] KIND_FALSE     = 4'd1;
  localparam logic [3:0] KIND_TRUE      = 4'd2;
  localparam logic [3:0] KIND_U32       = 4'd3;
  localparam logic [3:0] KIND_I32       = 4'd4;
  localparam logic [3:0] KIND_U64       = 4'd5;
  localparam logic [3:0] KIND_I64       = 4'd6;
  localparam logic [3:0] KIND_RAW_HDR   = 4'd7;
  localparam logic [3:0] KIND_RAW_BYTE  = 4'd8;
  localparam logic [3:0] KIND_ARRAY     = 4'd9;
  localparam logic [3:0] KIND_MAP       = 4'd10;
  localparam logic [3:0] KIND_TRUNCATED = 4'd11;
  localparam logic [3:0] KIND_FLOAT     = 4'd12;
  localparam logic [3:0] KIND_UNKNOWN   = 4'd13;

  localparam logic [7:0] TYPE_NIL    = 8'hc0;
  localparam logic [7:0] TYPE_FALSE  = 8'hc2;
  localparam logic [7:0] TYPE_TRUE   = 8'hc3;
  localparam logic [7:0] TYPE_FLOAT  = 8'hca;
  localparam logic [7:0] TYPE_DOUBLE = 8'hcb;
  localparam logic [7:0] TYPE_UINT8  = 8'hcc;
  localparam logic [7:0] TYPE_UINT16 = 8'hcd;
  localparam logic [7:0] TYPE_UINT32 = 8'hce;
  localparam logic [7:0] TYPE_UINT64 = 8'hcf;
  localparam logic [7:0] TYPE_INT8   = 8'hd0;
  localparam logic [7:0] TYPE_INT16  = 8'hd1;
  localparam logic [7:0] TYPE_INT32  = 8'hd2;
  localparam logic [7:0] TYPE_INT64  = 8'hd3;
  localparam logic [7:0] TYPE_RAW16  = 8'hda;
  localparam logic [7:0] TYPE_RAW32  = 8'hdb;
  localparam logic [7:0] TYPE_ARR16  = 8'hdc;
  localparam logic [7:0] TYPE_ARR32  = 8'hdd;
  localparam logic [7:0] TYPE_MAP16  = 8'hde;
  localparam logic [7:0] TYPE_MAP32  = 8'hdf;

  function automatic logic [3:0] arg_length(input logic [7:0] t);
    logic [3:0] n;
    case (t)
      TYPE_UINT8, TYPE_INT8: n = 4'd1;
      TYPE_UINT16, TYPE_INT16, TYPE_RAW16, TYPE_ARR16, TYPE_MAP16: n = 4'd2;
      TYPE_UINT32, TYPE_INT32, TYPE_RAW32, TYPE_ARR32, TYPE_MAP32: n = 4'd4;
      TYPE_UINT64, TYPE_INT64: n = 4'd8;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

/* src/msgpack_token_parser_top.sv */
// Byte-serial MessagePack token decoder, legacy raw-string form.
// Input channel (in_valid/in_ready/in_word): one buffer byte per word, with
// buffer_end set on the last byte of a buffer.
// Result channel (out_valid/out_ready/out_word): at most one token per input
// word: kind, 64-bit value (signed kinds sign-extended), and ends_buffer.
// Integer arguments, raw/array/map lengths are assembled big-endian over the
// following bytes; raw payload bytes pass through one token each.
// Floats and unknown type bytes are reported, then the rest of the buffer is
// dropped without results.
// Path: an accepted word is held in the stage register, decoded from there,
// and its token is written into the result register.
// Throughput: one word per cycle while the result channel is not stalled,
// set by the single decode step between the stage register and the result register.
// Reset: synchronous, active low; parser returns to idle awaiting a type
// byte and both registers empty.
// Stall: while out_ready is low and a token is held, the stage register
// fills and then in_ready drops; nothing is lost or repeated.
`default_nettype none

module msgpack_token_parser_top (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  msgp_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  wire                 out_ready,
  output msgp_pkg::out_word_t out_word
);
  import msgp_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ARG,
    PH_PAYLOAD,
    PH_DISCARD
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [3:0]  arg_left_r, arg_left_nxt;
  logic [63:0] asm_r, asm_nxt;
  logic [31:0] pay_left_r, pay_left_nxt;

  in_word_t    stage_word_r;
  logic        stage_valid_r;
  out_word_t   out_word_r;
  logic        out_valid_r;

  logic        advance, fire, emit;
  logic [3:0]  kind;
  logic [63:0] value;
  logic        endb;
  logic        raw_go;
  logic [31:0] raw_len;
  logic [7:0]  b;
  logic        e;
  logic [63:0] asm_shift;
  logic [3:0]  arg_dec;
  logic [3:0]  n_arg;
  logic [31:0] pay_dec;

  assign advance   = !out_valid_r || out_ready;
  assign fire      = stage_valid_r && advance;
  assign in_ready  = !stage_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign b         = stage_word_r.data_byte;
  assign e         = stage_word_r.buffer_end;
  assign asm_shift = {asm_r[55:0], b};
  assign arg_dec   = (arg_left_r != 4'd0) ? arg_left_r - 4'd1 : 4'd0;
  assign pay_dec   = (pay_left_r != 32'd0) ? pay_left_r - 32'd1 : 32'd0;
  assign n_arg     = arg_length(b);

  always_comb begin
    phase_nxt    = phase_r;
    held_nxt     = held_r;
    arg_left_nxt = arg_left_r;
    asm_nxt      = asm_r;
    pay_left_nxt = pay_left_r;
    emit         = 1'b0;
    kind         = KIND_NIL;
    value        = 64'd0;
    endb         = 1'b0;
    raw_go       = 1'b0;
    raw_len      = 32'd0;
    case (phase_r)
      PH_ARG: begin
        asm_nxt      = asm_shift;
        arg_left_nxt = arg_dec;
        if (arg_dec == 4'd0) begin
          phase_nxt = PH_IDLE;
          emit      = 1'b1;
          endb      = e;
          case (held_r)
            TYPE_UINT8, TYPE_UINT16, TYPE_UINT32: begin
              kind  = KIND_U32;
              value = {32'd0, asm_shift[31:0]};
            end
            TYPE_UINT64: begin
              kind  = KIND_U64;
              value = asm_shift;
            end
            TYPE_INT8: begin
              kind  = KIND_I32;
              value = {{56{asm_shift[7]}}, asm_shift[7:0]};
            end
            TYPE_INT16: begin
              kind  = KIND_I32;
              value = {{48{asm_shift[15]}}, asm_shift[15:0]};
            end
            TYPE_INT32: begin
              kind  = KIND_I32;
              value = {{32{asm_shift[31]}}, asm_shift[31:0]};
            end
            TYPE_INT64: begin
              kind  = KIND_I64;
              value = asm_shift;
            end
            TYPE_RAW16, TYPE_RAW32: begin
              emit    = 1'b0;
              raw_go  = 1'b1;
              raw_len = asm_shift[31:0];
            end
            TYPE_ARR16, TYPE_ARR32: begin
              kind  = KIND_ARRAY;
              value = {32'd0, asm_shift[31:0]};
            end
            TYPE_MAP16, TYPE_MAP32: begin
              kind  = KIND_MAP;
              value = {32'd0, asm_shift[31:0]};
            end
            default: begin
              kind = KIND_UNKNOWN;
              endb = 1'b1;
            end
          endcase
        end else if (e) begin
          phase_nxt    = PH_IDLE;
          arg_left_nxt = 4'd0;
          emit         = 1'b1;
          kind         = KIND_TRUNCATED;
          endb         = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        pay_left_nxt = pay_dec;
        emit         = 1'b1;
        if (pay_dec == 32'd0) begin
          phase_nxt = PH_IDLE;
          kind      = KIND_RAW_BYTE;
          value     = {56'd0, b};
          endb      = e;
        end else if (e) begin
          phase_nxt    = PH_IDLE;
          pay_left_nxt = 32'd0;
          kind         = KIND_TRUNCATED;
          endb         = 1'b1;
        end else begin
          kind  = KIND_RAW_BYTE;
          value = {56'd0, b};
        end
      end
      PH_DISCARD: begin
        if (e) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        emit = 1'b1;
        endb = e;
        if (n_arg != 4'd0) begin
          held_nxt = b;
          asm_nxt  = 64'd0;
          if (e) begin
            kind = KIND_TRUNCATED;
            endb = 1'b1;
          end else begin
            emit         = 1'b0;
            arg_left_nxt = n_arg;
            phase_nxt    = PH_ARG;
          end
        end else if (!b[7]) begin
          kind  = KIND_U32;
          value = {56'd0, b};
        end else if (b[7:5] == 3'b111) begin
          kind  = KIND_I32;
          value = {{56{1'b1}}, b};
        end else if (b[7:5] == 3'b101) begin
          emit    = 1'b0;
          raw_go  = 1'b1;
          raw_len = {27'd0, b[4:0]};
        end else if (b[7:4] == 4'h9) begin
          kind  = KIND_ARRAY;
          value = {60'd0, b[3:0]};
        end else if (b[7:4] == 4'h8) begin
          kind  = KIND_MAP;
          value = {60'd0, b[3:0]};
        end else if (b == TYPE_NIL) begin
          kind = KIND_NIL;
        end else if (b == TYPE_FALSE) begin
          kind = KIND_FALSE;
        end else if (b == TYPE_TRUE) begin
          kind = KIND_TRUE;
        end else begin
          phase_nxt = e ? PH_IDLE : PH_DISCARD;
          endb      = 1'b1;
          kind      = (b == TYPE_FLOAT || b == TYPE_DOUBLE) ? KIND_FLOAT : KIND_UNKNOWN;
        end
      end
    endcase
    if (raw_go) begin
      emit = 1'b1;
      if (raw_len == 32'd0) begin
        kind  = KIND_RAW_HDR;
        value = 64'd0;
        endb  = e;
      end else if (e) begin
        kind  = KIND_TRUNCATED;
        value = 64'd0;
        endb  = 1'b1;
      end else begin
        kind         = KIND_RAW_HDR;
        value        = {32'd0, raw_len};
        endb         = 1'b0;
        pay_left_nxt = raw_len;
        phase_nxt    = PH_PAYLOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      held_r        <= 8'd0;
      arg_left_r    <= 4'd0;
      asm_r         <= 64'd0;
      pay_left_r    <= 32'd0;
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        stage_word_r  <= in_word;
        stage_valid_r <= 1'b1;
      end else if (fire) begin
        stage_valid_r <= 1'b0;
      end
      if (fire) begin
        phase_r    <= phase_nxt;
        held_r     <= held_nxt;
        arg_left_r <= arg_left_nxt;
        asm_r      <= asm_nxt;
        pay_left_r <= pay_left_nxt;
      end
      if (advance) begin
        out_valid_r <= fire && emit;
      end
      if (fire && emit) begin
        out_word_r.token_kind  <= kind;
        out_word_r.token_value <= value;
        out_word_r.ends_buffer <= endb;
      end
    end
  end

  a_error_ends_buffer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_word_r.token_kind == KIND_TRUNCATED ||
                    out_word_r.token_kind == KIND_FLOAT ||
                    out_word_r.token_kind == KIND_UNKNOWN)
    |-> out_word_r.ends_buffer)
    else $error("error token without buffer end");

  a_arg_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ARG |-> arg_left_r != 4'd0)
    else $error("argument phase with no bytes left");

  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> pay_left_r != 32'd0)
    else $error("payload phase with no bytes left");

  a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && stage_word_r.buffer_end |=> phase_r == PH_IDLE)
    else $error("buffer end did not return parser to idle");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> stage_valid_r && out_valid_r && !out_ready)
    else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire

/* tb/tb_msgpack_token_parser_top.sv */
`default_nettype none

module tb_msgpack_token_parser_top;
  import msgp_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 600;

  localparam logic [7:0] FIXMAP_BASE = 8'h80;
  localparam logic [7:0] FIXARR_BASE = 8'h90;
  localparam logic [7:0] FIXRAW_BASE = 8'ha0;
  localparam logic [7:0] NEGFIX_BASE = 8'he0;
  localparam logic [7:0] UNKNOWN_C1  = 8'hc1;
  localparam logic [7:0] UNKNOWN_C4  = 8'hc4;
  localparam logic [7:0] UNKNOWN_D4  = 8'hd4;

  typedef enum logic [1:0] {PH_IDLE, PH_ARG, PH_PAYLOAD, PH_DISCARD} parse_phase_t;

  class token_scoreboard;
    parse_phase_t phase;
    logic [7:0]   held_type;
    logic [3:0]   args_left;
    logic [63:0]  acc;
    logic [31:0]  payload_left;
    out_word_t    pending[$];
    int           errors;

    function new();
      phase = PH_IDLE;
      held_type = 8'd0;
      args_left = 4'd0;
      acc = 64'd0;
      payload_left = 32'd0;
      errors = 0;
    endfunction

    function void push(logic [3:0] kind, logic [63:0] value, logic last);
      out_word_t w;
      w.token_kind = kind;
      w.token_value = value;
      w.ends_buffer = last;
      pending.push_back(w);
    endfunction

    function logic [3:0] arg_bytes(logic [7:0] t);
      case (t)
        TYPE_UINT8, TYPE_INT8: return 4'd1;
        TYPE_UINT16, TYPE_INT16, TYPE_RAW16, TYPE_ARR16, TYPE_MAP16: return 4'd2;
        TYPE_UINT32, TYPE_INT32, TYPE_RAW32, TYPE_ARR32, TYPE_MAP32: return 4'd4;
        TYPE_UINT64, TYPE_INT64: return 4'd8;
        default: return 4'd0;
      endcase
    endfunction

    function void raw_header(logic [31:0] len, logic last);
      if (len == 32'd0) begin
        push(KIND_RAW_HDR, 64'd0, last);
      end else if (last) begin
        push(KIND_TRUNCATED, 64'd0, 1'b1);
      end else begin
        payload_left = len;
        phase = PH_PAYLOAD;
        push(KIND_RAW_HDR, {32'd0, len}, 1'b0);
      end
    endfunction

    function void finish_arg(logic last);
      case (held_type)
        TYPE_UINT8, TYPE_UINT16, TYPE_UINT32: push(KIND_U32, {32'd0, acc[31:0]}, last);
        TYPE_UINT64: push(KIND_U64, acc, last);
        TYPE_INT8: push(KIND_I32, {{56{acc[7]}}, acc[7:0]}, last);
        TYPE_INT16: push(KIND_I32, {{48{acc[15]}}, acc[15:0]}, last);
        TYPE_INT32: push(KIND_I32, {{32{acc[31]}}, acc[31:0]}, last);
        TYPE_INT64: push(KIND_I64, acc, last);
        TYPE_RAW16, TYPE_RAW32: raw_header(acc[31:0], last);
        TYPE_ARR16, TYPE_ARR32: push(KIND_ARRAY, {32'd0, acc[31:0]}, last);
        TYPE_MAP16, TYPE_MAP32: push(KIND_MAP, {32'd0, acc[31:0]}, last);
        default: push(KIND_UNKNOWN, 64'd0, 1'b1);
      endcase
    endfunction

    function void take_type(logic [7:0] b, logic last);
      logic [3:0] n;
      n = arg_bytes(b);
      if (n != 4'd0) begin
        held_type = b;
        acc = 64'd0;
        if (last) begin
          push(KIND_TRUNCATED, 64'd0, 1'b1);
        end else begin
          args_left = n;
          phase = PH_ARG;
        end
      end else if (b < FIXMAP_BASE) begin
        push(KIND_U32, {56'd0, b}, last);
      end else if (b >= NEGFIX_BASE) begin
        push(KIND_I32, {56'hff_ffff_ffff_ffff, b}, last);
      end else if ((b & 8'he0) == FIXRAW_BASE) begin
        raw_header({27'd0, b[4:0]}, last);
      end else if ((b & 8'hf0) == FIXARR_BASE) begin
        push(KIND_ARRAY, {60'd0, b[3:0]}, last);
      end else if ((b & 8'hf0) == FIXMAP_BASE) begin
        push(KIND_MAP, {60'd0, b[3:0]}, last);
      end else if (b == TYPE_NIL) begin
        push(KIND_NIL, 64'd0, last);
      end else if (b == TYPE_FALSE) begin
        push(KIND_FALSE, 64'd0, last);
      end else if (b == TYPE_TRUE) begin
        push(KIND_TRUE, 64'd0, last);
      end else begin
        phase = last ? PH_IDLE : PH_DISCARD;
        if (b == TYPE_FLOAT || b == TYPE_DOUBLE) push(KIND_FLOAT, 64'd0, 1'b1);
        else push(KIND_UNKNOWN, 64'd0, 1'b1);
      end
    endfunction

    function void note_input(in_word_t w);
      logic [7:0] b;
      logic       last;
      b = w.data_byte;
      last = w.buffer_end;
      case (phase)
        PH_ARG: begin
          acc = {acc[55:0], b};
          if (args_left != 4'd0) args_left = args_left - 4'd1;
          if (args_left == 4'd0) begin
            phase = PH_IDLE;
            finish_arg(last);
          end else if (last) begin
            phase = PH_IDLE;
            args_left = 4'd0;
            push(KIND_TRUNCATED, 64'd0, 1'b1);
          end
        end
        PH_PAYLOAD: begin
          if (payload_left != 32'd0) payload_left = payload_left - 32'd1;
          if (payload_left == 32'd0) begin
            phase = PH_IDLE;
            push(KIND_RAW_BYTE, {56'd0, b}, last);
          end else if (last) begin
            phase = PH_IDLE;
            payload_left = 32'd0;
            push(KIND_TRUNCATED, 64'd0, 1'b1);
          end else begin
            push(KIND_RAW_BYTE, {56'd0, b}, 1'b0);
          end
        end
        PH_DISCARD: begin
          if (last) phase = PH_IDLE;
        end
        default: take_type(b, last);
      endcase
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        $error("token with nothing pending: kind %0d value %h", got.token_kind, got.token_value);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.token_kind !== want.token_kind) begin
        $error("token_kind expected %0d actual %0d", want.token_kind, got.token_kind);
        errors++;
      end
      if (got.token_value !== want.token_value) begin
        $error("token_value expected %h actual %h", want.token_value, got.token_value);
        errors++;
      end
      if (got.ends_buffer !== want.ends_buffer) begin
        $error("ends_buffer expected %0b actual %0b", want.ends_buffer, got.ends_buffer);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  token_scoreboard sb;
  logic [7:0]      stream[$];
  int              idle_pct = 0;
  int              stall_pct = 0;
  int              words_sent = 0;
  int              cycles = 0;
  bit              hold_pending = 1'b0;
  bit              hold_done = 1'b0;

  msgpack_token_parser_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_word);
      if (out_valid && out_ready) sb.check_result(out_word);
    end
  end

  initial begin
    forever begin
      if (hold_pending && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
        @(posedge clk);
      end
    end
  end

  task automatic send_word(input logic [7:0] b, input logic last);
    in_word_t w;
    w.data_byte = b;
    w.buffer_end = last;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      in_word <= in_word_t'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_stream();
    for (int i = 0; i < stream.size(); i++) begin
      send_word(stream[i], i == stream.size() - 1);
    end
  endtask

  function automatic void add_arg(int n);
    int mode;
    mode = $urandom_range(4);
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: stream.push_back(8'h00);
        1: stream.push_back(8'hff);
        2: stream.push_back(i == 0 ? 8'h80 : 8'h00);
        3: stream.push_back(i == 0 ? 8'h7f : 8'hff);
        default: stream.push_back(8'($urandom_range(255)));
      endcase
    end
  endfunction

  function automatic void add_payload(int len);
    repeat (len) stream.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void add_token();
    int         pick;
    int         len;
    logic [7:0] t;
    pick = $urandom_range(17);
    case (pick)
      0: stream.push_back(8'($urandom_range(127)));
      1: stream.push_back(NEGFIX_BASE | 8'($urandom_range(31)));
      2: begin
        len = $urandom_range(2);
        stream.push_back(len == 0 ? TYPE_NIL : (len == 1 ? TYPE_FALSE : TYPE_TRUE));
      end
      3, 4, 5, 6, 7: begin
        t = ($urandom_range(1) ? TYPE_UINT8 : TYPE_INT8) + 8'($urandom_range(3));
        stream.push_back(t);
        add_arg(1 << t[1:0]);
      end
      8, 9: begin
        len = $urandom_range(3) == 0 ? $urandom_range(31) : $urandom_range(4);
        stream.push_back(FIXRAW_BASE | 8'(len));
        add_payload(len);
      end
      10: begin
        len = $urandom_range(12);
        if ($urandom_range(1)) begin
          stream.push_back(TYPE_RAW16);
          stream.push_back(8'h00);
        end else begin
          stream.push_back(TYPE_RAW32);
          repeat (3) stream.push_back(8'h00);
        end
        stream.push_back(8'(len));
        add_payload(len);
      end
      11: stream.push_back(FIXARR_BASE | 8'($urandom_range(15)));
      12: stream.push_back(FIXMAP_BASE | 8'($urandom_range(15)));
      13: begin
        t = TYPE_ARR16 + 8'($urandom_range(3));
        stream.push_back(t);
        add_arg(t[0] ? 4 : 2);
      end
      14: stream.push_back($urandom_range(1) ? TYPE_FLOAT : TYPE_DOUBLE);
      15: begin
        len = $urandom_range(12);
        if (len == 0) stream.push_back(UNKNOWN_C1);
        else if (len <= 6) stream.push_back(8'(UNKNOWN_C4 + len - 1));
        else stream.push_back(8'(UNKNOWN_D4 + len - 7));
      end
      16: begin
        stream.push_back($urandom_range(1) ? TYPE_RAW16 : TYPE_RAW32);
        add_arg(stream[stream.size() - 1] == TYPE_RAW16 ? 2 : 4);
        add_payload($urandom_range(1, 6));
      end
      default: begin
        stream.push_back(TYPE_UINT64 + ($urandom_range(1) ? 8'h04 : 8'h00));
        add_arg(8);
      end
    endcase
  endfunction

  task automatic send_buffer();
    int mix;
    int keep;
    mix = $urandom_range(99);
    stream.delete();
    if (mix < 13) begin
      repeat ($urandom_range(1, 8)) stream.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 5)) add_token();
      if (mix < 25 && stream.size() > 1) begin
        keep = $urandom_range(1, stream.size() - 1);
        while (stream.size() > keep) void'(stream.pop_back());
      end
    end
    send_stream();
  endtask

  task automatic run_phase(input int idle, input int stall, input int count);
    int start;
    idle_pct = idle;
    stall_pct = stall;
    start = words_sent;
    while (words_sent - start < count) send_buffer();
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(8'h00, 1'b0); send_word(8'h7f, 1'b0); send_word(8'he0, 1'b0);
    send_word(8'hff, 1'b0);
    send_word(TYPE_NIL, 1'b0); send_word(TYPE_FALSE, 1'b0); send_word(TYPE_TRUE, 1'b0);
    send_word(TYPE_INT16, 1'b0); send_word(8'h80, 1'b0); send_word(8'h00, 1'b0);
    send_word(FIXRAW_BASE | 8'd2, 1'b0); send_word(8'h41, 1'b0); send_word(8'h42, 1'b0);
    send_word(FIXRAW_BASE, 1'b0);
    send_word(FIXARR_BASE | 8'd3, 1'b0); send_word(FIXMAP_BASE | 8'd15, 1'b0);
    send_word(TYPE_DOUBLE, 1'b0); send_word(8'h55, 1'b0); send_word(8'h00, 1'b1);
    send_word(TYPE_UINT16, 1'b1);
    send_word(FIXRAW_BASE | 8'd3, 1'b1);
    send_word(FIXRAW_BASE | 8'd2, 1'b0); send_word(8'h41, 1'b1);
    send_word(UNKNOWN_C1, 1'b1);
    send_word(TYPE_FLOAT, 1'b1);

    run_phase(0, 0, 400);
    run_phase(65, 0, 400);
    run_phase(0, 65, 400);
    run_phase(27, 27, 400);

    stall_pct = 27;
    idle_pct = 0;
    hold_pending = 1'b1;
    run_phase(0, 27, 80);
    wait (hold_done);
    run_phase(0, 27, 300);

    in_valid <= 1'b0;
    stall_pct = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
src/msgp_pkg.sv
src/msgpack_token_parser_top.sv
tb/tb_msgpack_token_parser_top.sv
